// ----- hw/rtl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam logic       REQ_ALLOC          = 1'b0;
	localparam logic       REQ_FREE           = 1'b1;
	localparam logic [7:0] SLOT_COUNT_RST     = 8'd128;
	localparam int         SLOT_W             = 7;
	localparam int         COUNT_W            = 8;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	// one queued request, classified by the front end
	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot;
		logic              range_err;
	} req_ent_t;

endpackage

// ----- hw/rtl/bsa_if.sv -----
// ----------------------------------------------------------------------------
// bsa_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface bsa_req_if;
	logic                       valid;
	logic                       ready;
	logic                       req_type;
	logic [bsa_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output req_type, output slot, input ready);
	modport sink   (input valid, input req_type, input slot, output ready);
endinterface

interface bsa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [bsa_pkg::SLOT_W-1:0]  granted_slot;
	logic [bsa_pkg::COUNT_W-1:0] used_count;

	modport source (output valid, output status, output granted_slot, output used_count,
		input ready);
	modport sink   (input valid, input status, input granted_slot, input used_count,
		output ready);
endinterface

// ----- hw/rtl/bsa_front.sv -----
// ----------------------------------------------------------------------------
// bsa_front
// Accepts requests, flags out-of-range frees, and queues them (2 entries).
// ----------------------------------------------------------------------------
module bsa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bsa_pkg::COUNT_W-1:0] limit,
	bsa_req_if.sink                     req,
	output logic                        q_valid,
	output bsa_pkg::req_ent_t           q_head,
	input  logic                        q_pop
);

	bsa_pkg::req_ent_t ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              push;
	bsa_pkg::req_ent_t new_ent;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_head    = ent_q[rd_ptr_q];

	always_comb begin
		new_ent.req_type  = req.req_type;
		new_ent.slot      = req.slot;
		new_ent.range_err = ({1'b0, req.slot} >= limit);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/bsa_back.sv -----
// ----------------------------------------------------------------------------
// bsa_back
// Executes queued requests against the usage bitmap, one group per cycle.
// ----------------------------------------------------------------------------
module bsa_back #(
	parameter int CAPACITY    = 128,
	parameter int GROUP_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bsa_pkg::COUNT_W-1:0] limit,
	input  logic                        q_valid,
	input  bsa_pkg::req_ent_t           q_head,
	output logic                        q_pop,
	bsa_rsp_if.source                   rsp
);

	localparam int NUM_GROUPS = (CAPACITY + GROUP_WIDTH - 1) / GROUP_WIDTH;
	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int BIT_W      = $clog2(GROUP_WIDTH);
	localparam int SPAN_W     = $clog2(NUM_GROUPS * GROUP_WIDTH + 1);
	localparam int CMP_W      = (SPAN_W > 9) ? SPAN_W : 9;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREAD,
		S_FCHK
	} state_t;

	state_t                        state_q;
	logic [GRP_W-1:0]              grp_q;
	logic [CMP_W-1:0]              base_q;
	logic [BIT_W-1:0]              rem_q;
	logic [bsa_pkg::COUNT_W-1:0]   total_q;
	logic                          rsp_valid_q;
	bsa_pkg::status_t              status_q;
	logic [bsa_pkg::SLOT_W-1:0]    granted_q;

	logic [GROUP_WIDTH-1:0] mem [NUM_GROUPS];
	logic [GROUP_WIDTH-1:0] rd_data_q;
	logic                   rd_en;
	logic [GRP_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [GRP_W-1:0]       wr_addr;
	logic [GROUP_WIDTH-1:0] wr_data;

	logic                   out_free;
	logic [CMP_W-1:0]       rem_lim;
	logic [CMP_W-1:0]       next_base;
	logic                   found;
	logic [BIT_W-1:0]       free_idx;
	logic                   last_grp;
	logic                   bit_set;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign q_pop     = (state_q == S_IDLE) && q_valid && out_free;
	assign rem_lim   = CMP_W'(limit) - base_q;
	assign next_base = base_q + CMP_W'(GROUP_WIDTH);
	assign last_grp  = (grp_q == GRP_W'(NUM_GROUPS - 1));
	assign bit_set   = rd_data_q[rem_q];

	// lowest clear bit below the limit
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int b = GROUP_WIDTH - 1; b >= 0; b--) begin
			if (!rd_data_q[b] && (CMP_W'(b) < rem_lim)) begin
				found    = 1'b1;
				free_idx = BIT_W'(b);
			end
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = grp_q;
		wr_en   = 1'b0;
		wr_addr = grp_q;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_IDLE: begin
				rd_en   = q_pop;
				rd_addr = '0;
			end
			S_SCAN: begin
				if (found) begin
					wr_en   = 1'b1;
					wr_data = rd_data_q | (GROUP_WIDTH'(1) << free_idx);
				end else begin
					rd_en   = 1'b1;
					rd_addr = GRP_W'(grp_q + 1'b1);
				end
			end
			S_FREAD: begin
				rd_en = 1'b1;
			end
			S_FCHK: begin
				wr_en   = bit_set;
				wr_data = rd_data_q & ~(GROUP_WIDTH'(1) << rem_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			grp_q       <= '0;
			base_q      <= '0;
			rem_q       <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= bsa_pkg::ST_OK;
			granted_q   <= '0;
		end else begin
			if (rsp.valid && rsp.ready && !q_pop) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (last_grp) begin
						grp_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						grp_q <= GRP_W'(grp_q + 1'b1);
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						base_q <= '0;
						rem_q  <= q_head.slot[BIT_W-1:0];
						if (q_head.req_type == bsa_pkg::REQ_ALLOC) begin
							grp_q <= '0;
							if (total_q >= limit) begin
								status_q    <= bsa_pkg::ST_FULL;
								granted_q   <= '0;
								rsp_valid_q <= 1'b1;
							end else begin
								rsp_valid_q <= 1'b0;
								state_q     <= S_SCAN;
							end
						end else if (q_head.range_err) begin
							status_q    <= bsa_pkg::ST_RANGE;
							granted_q   <= '0;
							rsp_valid_q <= 1'b1;
						end else begin
							grp_q       <= GRP_W'(q_head.slot >> BIT_W);
							rsp_valid_q <= 1'b0;
							state_q     <= S_FREAD;
						end
					end
				end
				S_SCAN: begin
					if (found) begin
						total_q     <= total_q + 1'b1;
						status_q    <= bsa_pkg::ST_OK;
						granted_q   <= bsa_pkg::SLOT_W'(base_q + CMP_W'(free_idx));
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (last_grp || (next_base >= CMP_W'(limit))) begin
						status_q    <= bsa_pkg::ST_FULL;
						granted_q   <= '0;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						grp_q  <= GRP_W'(grp_q + 1'b1);
						base_q <= next_base;
					end
				end
				S_FREAD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					granted_q   <= '0;
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
					if (bit_set) begin
						status_q <= bsa_pkg::ST_OK;
						if (total_q != '0) begin
							total_q <= total_q - 1'b1;
						end
					end else begin
						status_q <= bsa_pkg::ST_NOT_ALLOC;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.granted_slot = granted_q;
	assign rsp.used_count   = total_q;

endmodule

// ----- hw/rtl/bitmap_slot_allocator_top.sv -----
// Sequence: an allocate scans G bitmap groups in S_SCAN, G from 1 to the group count;
// early full and out-of-range answers come straight from S_IDLE; a free passes S_FREAD, S_FCHK.
// The back end executes one item at a time: an allocate holds it for its whole group scan,
// and a new item is taken only once the response register is free. A 2-entry request queue
// decouples input from execution.
// Reset: count cleared, slot_count = 128; then a clearing pass over all bitmap groups
// zeroes the bitmap before the first item is executed.
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top
// First-free slot allocator over a grouped usage bitmap.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top #(
	parameter int CAPACITY    = 128,
	parameter int GROUP_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bsa_pkg::COUNT_W-1:0] cfg_wdata,
	bsa_req_if.sink                     req,
	bsa_rsp_if.source                   rsp
);

	localparam int CAP_CLIP = (CAPACITY > 255) ? 255 : CAPACITY;

	logic [bsa_pkg::COUNT_W-1:0] slot_count_q;
	logic [bsa_pkg::COUNT_W-1:0] limit;
	logic                        q_valid;
	logic                        q_pop;
	bsa_pkg::req_ent_t           q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= bsa_pkg::SLOT_COUNT_RST;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	assign limit = (slot_count_q > bsa_pkg::COUNT_W'(CAP_CLIP)) ?
		bsa_pkg::COUNT_W'(CAP_CLIP) : slot_count_q;

	bsa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (limit),
		.req     (req),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	bsa_back #(
		.CAPACITY    (CAPACITY),
		.GROUP_WIDTH (GROUP_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (limit),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule
